FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the quaternion to Euler block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/core/qte_pkg.sv
// Shared widths, constants and the CORDIC angle table for quaternion_to_euler.
// No dependencies.
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 7;

  localparam int Q_W        = 16;  // quaternion component width
  localparam int PROD_W     = 32;  // Q2.30 product width
  localparam int SUM_W      = 34;  // doubled sums of products
  localparam int CW         = 38;  // CORDIC vector width
  localparam int ZW         = 26;  // CORDIC angle width, degrees Q.16
  localparam int INT_FRAC   = 16;  // fraction bits of the CORDIC angle
  localparam int ATAN_LEN   = 24;
  localparam int ISQ_W      = 62;  // square-root radicand width
  localparam int ROOT_W     = 31;  // square-root result width
  localparam int ISQ_STAGES = 31;  // one result bit per stage
  localparam int A_W        = 32;  // in-range asin argument width

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(2949120);
      1:  v = ZW'(1740967);
      2:  v = ZW'(919879);
      3:  v = ZW'(466945);
      4:  v = ZW'(234379);
      5:  v = ZW'(117304);
      6:  v = ZW'(58666);
      7:  v = ZW'(29335);
      8:  v = ZW'(14668);
      9:  v = ZW'(7334);
      10: v = ZW'(3667);
      11: v = ZW'(1833);
      12: v = ZW'(917);
      13: v = ZW'(458);
      14: v = ZW'(229);
      15: v = ZW'(115);
      16: v = ZW'(57);
      17: v = ZW'(29);
      18: v = ZW'(14);
      19: v = ZW'(7);
      20: v = ZW'(4);
      21: v = ZW'(2);
      22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/qte_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ISQ_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [ISQ_W-1:0] v_q   [0:ISQ_STAGES-1];
  logic [ISQ_W-1:0] res_q [0:ISQ_STAGES-1];

  for (genvar j = 0; j < ISQ_STAGES; j++) begin : g_stage
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STAGES - 1 - j));
    logic [ISQ_W-1:0] v_in, res_in, trial;

    // take operands from the previous stage or the input
    if (j == 0) begin : g_first
      assign v_in   = radicand;
      assign res_in = '0;
    end else begin : g_rest
      assign v_in   = v_q[j-1];
      assign res_in = res_q[j-1];
    end
    assign trial = res_in + BIT;

    // decide one root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          v_q[j]   <= v_in - trial;
          res_q[j] <= (res_in >> 1) + BIT;
        end else begin
          v_q[j]   <= v_in;
          res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

FILE: rtl/core/qte_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees with 16 fraction bits.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [ZW-1:0] angle
);

  localparam logic signed [ZW-1:0] Z90 = ZW'(90) <<< INT_FRAC;

  logic signed [CW-1:0] x_q [0:STEPS];
  logic signed [CW-1:0] y_q [0:STEPS];
  logic signed [ZW-1:0] z_q [0:STEPS];
  logic                 zero_q [0:STEPS];

  // fold the left half plane into the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zero_q[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[CW-1]) begin
        if (!y_in[CW-1]) begin
          x_q[0] <= y_in;
          y_q[0] <= -x_in;
          z_q[0] <= Z90;
        end else begin
          x_q[0] <= -y_in;
          y_q[0] <= x_in;
          z_q[0] <= -Z90;
        end
      end else begin
        x_q[0] <= x_in;
        y_q[0] <= y_in;
        z_q[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_deg(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_deg(i);
        end
      end
    end
  end

  // atan2 of the zero vector is zero
  assign angle = zero_q[STEPS] ? '0 : z_q[STEPS];

endmodule

FILE: rtl/core/quaternion_to_euler.sv
// Quaternion to Euler angle converter, top level.
// Depends on qte_pkg, qte_isqrt, qte_cordic and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one quaternion qw, qx, qy, qz
//   in signed Q1.15. Output channel (out_valid/out_ready) carries roll_x,
//   pitch_y, yaw_z in 1/2^ANGLE_FRAC_BITS degree units and pitch_clamped,
//   which is set when the asin argument fell outside the unit range.
//   The path runs through the product, sum, range-check, square and
//   radicand registers, 31 square-root stages, the CORDIC stages and one
//   output register. Throughput is one transaction per cycle unless stalled.
//   Yaw and roll run their CORDICs early and their angles wait in a delay
//   line for the pitch path, which needs the square root first.
//   The whole pipeline advances together; when the receiver holds
//   out_ready low with a result waiting, every stage holds and in_ready
//   drops, so nothing is lost or repeated.
//   Reset clears all valid bits; no state survives between transactions.
`include "assert_macros.svh"
module quaternion_to_euler import qte_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [Q_W-1:0] qw,
  input  logic signed [Q_W-1:0] qx,
  input  logic signed [Q_W-1:0] qy,
  input  logic signed [Q_W-1:0] qz,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    roll_x,
  output logic signed [14:0]    pitch_y,
  output logic signed [15:0]    yaw_z,
  output logic                  pitch_clamped
);

  localparam int L_C   = CORDIC_STEPS + 1;
  localparam int ROOT_EDGE = 5 + ISQ_STAGES;
  localparam int ANG_D = ROOT_EDGE - 2;
  localparam int FLG_D = ROOT_EDGE + L_C - 3;
  localparam int LAT   = ROOT_EDGE + L_C + 1;
  localparam int SH    = INT_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0]    RND    = ZW'(64'd1 << (SH - 1));
  localparam logic signed [ZW-1:0]    LIM180 = ZW'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0]    LIM90  = ZW'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] A_UNIT = SUM_W'(1) <<< 30;
  localparam logic [ISQ_W-1:0]        ONE60  = ISQ_W'(1) << 60;
  localparam logic signed [14:0]      P90    = LIM90[14:0];
  localparam logic signed [14:0]      N90    = 15'(-LIM90);

  typedef struct packed {
    logic clamped;
    logic neg;
  } pitch_flags_t;

  logic en;
  logic [LAT:1] vld;

  // round to the output grid and limit to +-lim output units
  function automatic logic signed [ZW-1:0] round_lim(input logic signed [ZW-1:0] z,
                                                     input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    r = (z + RND) >>> SH;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  // advance whenever the output register is free or being drained
  assign en        = !vld[LAT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // stage 1: products
  logic signed [PROD_W-1:0] p_xy, p_zw, p_yz, p_xw, p_yw, p_xz;
  logic signed [PROD_W-1:0] p_xx, p_yy, p_zz, p_ww;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xy <= qx * qy;
      p_zw <= qz * qw;
      p_yz <= qy * qz;
      p_xw <= qx * qw;
      p_yw <= qy * qw;
      p_xz <= qx * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_ww <= qw * qw;
    end
  end

  // stage 2: atan2 operands and the asin argument
  logic signed [SUM_W-1:0] yaw_y, yaw_x, roll_y, roll_xv, a_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_y   <= (SUM_W'(p_xy) + SUM_W'(p_zw)) <<< 1;
      yaw_x   <= SUM_W'(p_xx) - SUM_W'(p_yy) - SUM_W'(p_zz) + SUM_W'(p_ww);
      roll_y  <= (SUM_W'(p_yz) + SUM_W'(p_xw)) <<< 1;
      roll_xv <= SUM_W'(p_zz) + SUM_W'(p_ww) - SUM_W'(p_xx) - SUM_W'(p_yy);
      a_s2    <= (SUM_W'(p_yw) - SUM_W'(p_xz)) <<< 1;
    end
  end

  // stage 3: range check and magnitude of the asin argument
  pitch_flags_t       flg_s3;
  logic [ROOT_W-1:0]  mag_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      flg_s3.clamped <= (a_s2 > A_UNIT) || (a_s2 < -A_UNIT);
      flg_s3.neg     <= a_s2[SUM_W-1];
      if ((a_s2 > A_UNIT) || (a_s2 < -A_UNIT)) begin
        mag_s3 <= '0;
      end else if (a_s2[SUM_W-1]) begin
        mag_s3 <= ROOT_W'(-a_s2);
      end else begin
        mag_s3 <= ROOT_W'(a_s2);
      end
    end
  end

  // stage 4: square; stage 5: radicand 1 - a^2
  logic [ISQ_W-1:0] aa_s4, rem_s5;

  always_ff @(posedge clk) begin
    if (en) begin
      aa_s4  <= ISQ_W'(mag_s3) * ISQ_W'(mag_s3);
      rem_s5 <= ONE60 - aa_s4;
    end
  end

  logic [ROOT_W-1:0] root;

  qte_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rem_s5),
    .root     (root)
  );

  // yaw and roll CORDICs start from stage 2
  logic signed [ZW-1:0] yaw_ang, roll_ang, pitch_ang;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (CW'(yaw_x)),
    .y_in  (CW'(yaw_y)),
    .angle (yaw_ang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (CW'(roll_xv)),
    .y_in  (CW'(roll_y)),
    .angle (roll_ang)
  );

  // delay lines that line the paths up with the square root and the pitch CORDIC
  logic signed [ZW-1:0]  yaw_d  [0:ANG_D-1];
  logic signed [ZW-1:0]  roll_d [0:ANG_D-1];
  logic signed [A_W-1:0] a_d    [0:ANG_D-1];
  pitch_flags_t          flg_d  [0:FLG_D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_d[0]  <= yaw_ang;
      roll_d[0] <= roll_ang;
      a_d[0]    <= A_W'(a_s2);
      for (int k = 1; k < ANG_D; k++) begin
        yaw_d[k]  <= yaw_d[k-1];
        roll_d[k] <= roll_d[k-1];
        a_d[k]    <= a_d[k-1];
      end
      flg_d[0] <= flg_s3;
      for (int k = 1; k < FLG_D; k++) begin
        flg_d[k] <= flg_d[k-1];
      end
    end
  end

  // pitch = atan2(a, sqrt(1 - a^2))
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (CW'($signed({1'b0, root}))),
    .y_in  (CW'(a_d[ANG_D-1])),
    .angle (pitch_ang)
  );

  // output register: round, limit, saturate pitch
  logic signed [ZW-1:0] yaw_r, roll_r, pitch_r;
  pitch_flags_t         flg_o;

  always_comb begin
    flg_o  = flg_d[FLG_D-1];
    yaw_r  = round_lim(yaw_d[ANG_D-1], LIM180);
    roll_r = round_lim(roll_d[ANG_D-1], LIM180);
    if (flg_o.clamped) begin
      pitch_r = flg_o.neg ? -LIM90 : LIM90;
    end else begin
      pitch_r = round_lim(pitch_ang, LIM90);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_x        <= roll_r[15:0];
      pitch_y       <= pitch_r[14:0];
      yaw_z         <= yaw_r[15:0];
      pitch_clamped <= flg_o.clamped;
    end
  end

  `ASSERT_NEXT(a_stall_freezes, !en, $stable(vld))
  `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld[1])
  `ASSERT_IMPL(a_clamp_value, out_valid && pitch_clamped, (pitch_y == P90) || (pitch_y == N90))

endmodule
